// File: rtl/fcl_pkg.sv
// shared types and constants of the int16 fully connected layer
`default_nettype none

package fcl_pkg;

    localparam int MAX_IN_DEF  = 16;
    localparam int MAX_OUT_DEF = 16;
    localparam int DIM_CAP     = 16;

    localparam int MODE_W     = 2;
    localparam int ROW_W      = 4;
    localparam int COL_W      = 4;
    localparam int VAL_W      = 16;
    localparam int DIM_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [MODE_W-1:0] MODE_WEIGHT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIAS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INPUT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_DIM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_EN = 2'd2;

    localparam logic [DIM_W-1:0]      IN_DIM_RST  = 5'd4;
    localparam logic [DIM_W-1:0]      OUT_DIM_RST = 5'd3;
    localparam logic                  BIAS_EN_RST = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
        logic                    last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [ROW_W-1:0]        result_row;
        logic                    last_row;
    } t_out_item;

    typedef struct packed {
        logic                    w_en;
        logic                    b_en;
        logic                    x_en;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
    } t_wr;

    typedef struct packed {
        logic             en;
        logic             is_bias;
        logic [ROW_W-1:0] row;
        logic [DIM_W-1:0] col;
    } t_rd;

    typedef struct packed {
        logic valid;
        logic is_bias;
    } t_slot;

endpackage

`default_nettype wire

// File: rtl/fcl_in_if.sv
// input transaction channel: load items for weights, biases and input elements
`default_nettype none

interface fcl_in_if;
    import fcl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    logic                    last_element;

    modport source (output valid, output mode, output row, output column, output value,
                    output last_element, input ready);
    modport sink   (input valid, input mode, input row, input column, input value,
                    input last_element, output ready);
endinterface

`default_nettype wire

// File: rtl/fcl_out_if.sv
// output transaction channel: one result row per transaction
`default_nettype none

interface fcl_out_if;
    import fcl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [ROW_W-1:0]        result_row;
    logic                    last_row;

    modport source (output valid, output result_value, output result_row, output last_row,
                    input ready);
    modport sink   (input valid, input result_value, input result_row, input last_row,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/fcl_store.sv
// weight/bias memory and input vector memory, synchronous read
`default_nettype none

module fcl_store #(
    parameter int MAX_IN  = fcl_pkg::MAX_IN_DEF,
    parameter int MAX_OUT = fcl_pkg::MAX_OUT_DEF
) (
    input  wire logic                           i_clk,
    input  wire fcl_pkg::t_wr                   i_wr,
    input  wire fcl_pkg::t_rd                   i_rd,
    output logic signed [fcl_pkg::VAL_W-1:0]    o_wdata,
    output logic signed [fcl_pkg::VAL_W-1:0]    o_xdata
);
    import fcl_pkg::*;

    localparam int LIM_IN  = (MAX_IN  < DIM_CAP) ? MAX_IN  : DIM_CAP;
    localparam int LIM_OUT = (MAX_OUT < DIM_CAP) ? MAX_OUT : DIM_CAP;
    localparam int WCOLS   = LIM_IN + 1;
    localparam int WDEPTH  = LIM_OUT * WCOLS;
    localparam int WAW     = $clog2(WDEPTH);
    localparam int IAW     = (LIM_IN > 1) ? $clog2(LIM_IN) : 1;

    logic signed [VAL_W-1:0] r_wmem [WDEPTH];
    logic signed [VAL_W-1:0] r_xmem [LIM_IN];

    logic           w_row_ok;
    logic           w_col_ok;
    logic           w_wmem_we;
    logic           w_xmem_we;
    logic [WAW-1:0] w_waddr;
    logic [WAW-1:0] w_raddr;
    logic [IAW-1:0] w_xwaddr;
    logic [IAW-1:0] w_xraddr;

    // row and bias slot share one memory row; bias sits after the last column
    assign w_row_ok  = ({1'b0, i_wr.row} < (ROW_W+1)'(LIM_OUT));
    assign w_col_ok  = ({1'b0, i_wr.column} < (COL_W+1)'(LIM_IN));
    assign w_wmem_we = (i_wr.w_en && w_row_ok && w_col_ok) || (i_wr.b_en && w_row_ok);
    assign w_xmem_we = i_wr.x_en && w_col_ok;

    assign w_waddr  = WAW'(int'(i_wr.row) * WCOLS
                           + (i_wr.b_en ? LIM_IN : int'(i_wr.column)));
    assign w_raddr  = WAW'(int'(i_rd.row) * WCOLS
                           + (i_rd.is_bias ? LIM_IN : int'(i_rd.col)));
    assign w_xwaddr = IAW'(i_wr.column);
    assign w_xraddr = IAW'(i_rd.col);

    always_ff @(posedge i_clk) begin
        if (w_wmem_we) begin
            r_wmem[w_waddr] <= i_wr.value;
        end
        if (i_rd.en) begin
            o_wdata <= r_wmem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xmem_we) begin
            r_xmem[w_xwaddr] <= i_wr.value;
        end
        if (i_rd.en && !i_rd.is_bias) begin
            o_xdata <= r_xmem[w_xraddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/fcl_mac.sv
// product register and row accumulator, wraps modulo 2^16
`default_nettype none

module fcl_mac (
    input  wire logic                           i_clk,
    input  wire logic signed [fcl_pkg::VAL_W-1:0] i_wdata,
    input  wire logic signed [fcl_pkg::VAL_W-1:0] i_xdata,
    input  wire fcl_pkg::t_slot                 i_s1,
    input  wire logic                           i_s2_valid,
    input  wire logic                           i_bias_en,
    input  wire logic                           i_acc_clr,
    output logic signed [fcl_pkg::VAL_W-1:0]    o_acc
);
    import fcl_pkg::*;

    logic signed [2*VAL_W-1:0] w_full;
    logic signed [VAL_W-1:0]   n_prod;
    logic signed [VAL_W-1:0]   r_prod;
    logic signed [VAL_W-1:0]   r_acc;

    assign w_full = i_wdata * i_xdata;

    always_comb begin
        if (i_s1.is_bias) begin
            n_prod = i_bias_en ? i_wdata : '0;
        end else begin
            n_prod = w_full[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_acc_clr) begin
            r_acc <= '0;
        end else if (i_s2_valid) begin
            r_acc <= r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// File: rtl/fcl_ctrl.sv
// load decode, row/column sequencer and output register
`default_nettype none

module fcl_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire fcl_pkg::t_in_item           i_item,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [fcl_pkg::DIM_W-1:0]   i_ni,
    input  wire logic [fcl_pkg::DIM_W-1:0]   i_no,
    input  wire logic signed [fcl_pkg::VAL_W-1:0] i_acc,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output fcl_pkg::t_out_item               o_out,
    output fcl_pkg::t_wr                     o_wr,
    output fcl_pkg::t_rd                     o_rd,
    output fcl_pkg::t_slot                   o_s1,
    output logic                             o_s2_valid,
    output logic                             o_acc_clr
);
    import fcl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] r_col, n_col;
    t_slot            r_s1, n_s1;
    logic             r_s2_valid;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic w_in_acc;
    logic w_start;
    logic w_out_free;
    logic w_last_row;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_start    = w_in_acc && (i_item.mode == MODE_INPUT) && i_item.last_element
                        && (i_no != '0);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_last_row = (({1'b0, r_row} + (ROW_W+1)'(1)) == i_no);

    always_comb begin
        o_wr.w_en   = w_in_acc && (i_item.mode == MODE_WEIGHT);
        o_wr.b_en   = w_in_acc && (i_item.mode == MODE_BIAS);
        o_wr.x_en   = w_in_acc && (i_item.mode == MODE_INPUT);
        o_wr.row    = i_item.row;
        o_wr.column = i_item.column;
        o_wr.value  = i_item.value;
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_s1        = '0;
        o_rd        = '0;
        o_acc_clr   = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state   = S_RUN;
                    n_row     = '0;
                    n_col     = '0;
                    o_acc_clr = 1'b1;
                end
            end
            S_RUN: begin
                o_rd.en      = 1'b1;
                o_rd.row     = r_row;
                o_rd.col     = r_col;
                o_rd.is_bias = (r_col == i_ni);
                n_s1.valid   = 1'b1;
                n_s1.is_bias = o_rd.is_bias;
                if (o_rd.is_bias) begin
                    n_col   = '0;
                    n_state = S_WAIT;
                end else begin
                    n_col = r_col + DIM_W'(1);
                end
            end
            S_WAIT: begin
                if (!r_s1.valid && !r_s2_valid && w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = i_acc;
                    n_out.result_row   = r_row;
                    n_out.last_row     = w_last_row;
                    o_acc_clr          = 1'b1;
                    if (w_last_row) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_s1        <= '0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_s1        <= n_s1;
            r_s2_valid  <= r_s1.valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_s1        = r_s1;
    assign o_s2_valid  = r_s2_valid;

endmodule

`default_nettype wire

// File: rtl/int16_fully_connected_layer_top.sv
// top level of the int16 fully connected layer
`default_nettype none

// Signed 16-bit fully connected layer y = W*x + b. Each input transaction loads at most one
// weight, bias or input element. An input element flagged last starts a run, if out_dim is
// not zero, that gives out_dim (capped at MAX_OUT) result transactions in row order, the final
// one marked last_row. Each row reads one weight per cycle from the single read port of the
// weight memory into one multiplier, then the bias, then drains the read, multiply and
// accumulate stages. Input transactions are not taken during a run; a finished row waits in
// the output register without holding up loads once the run is over. There is no clearing
// pass after reset; a run must only read entries that were loaded before. Configuration must
// be written only while the block is idle; the block itself does not enforce this.
module int16_fully_connected_layer_top #(
    parameter int MAX_IN  = fcl_pkg::MAX_IN_DEF,
    parameter int MAX_OUT = fcl_pkg::MAX_OUT_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    fcl_in_if.sink                                i_in,
    fcl_out_if.source                             o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [fcl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fcl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fcl_pkg::*;

    localparam int LIM_IN  = (MAX_IN  < DIM_CAP) ? MAX_IN  : DIM_CAP;
    localparam int LIM_OUT = (MAX_OUT < DIM_CAP) ? MAX_OUT : DIM_CAP;

    logic [DIM_W-1:0] r_in_dim;
    logic [DIM_W-1:0] r_out_dim;
    logic             r_bias_en;

    logic [DIM_W-1:0]        w_ni;
    logic [DIM_W-1:0]        w_no;
    t_in_item                w_item;
    t_out_item               w_out;
    t_wr                     w_wr;
    t_rd                     w_rd;
    t_slot                   w_s1;
    logic                    w_s2_valid;
    logic                    w_acc_clr;
    logic signed [VAL_W-1:0] w_acc;
    logic signed [VAL_W-1:0] w_wdata;
    logic signed [VAL_W-1:0] w_xdata;
    logic                    w_in_ready;
    logic                    w_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dim  <= IN_DIM_RST;
            r_out_dim <= OUT_DIM_RST;
            r_bias_en <= BIAS_EN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IN_DIM:  r_in_dim  <= i_cfg_data;
                CFG_OUT_DIM: r_out_dim <= i_cfg_data;
                CFG_BIAS_EN: r_bias_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_ni = (r_in_dim  > DIM_W'(LIM_IN))  ? DIM_W'(LIM_IN)  : r_in_dim;
    assign w_no = (r_out_dim > DIM_W'(LIM_OUT)) ? DIM_W'(LIM_OUT) : r_out_dim;

    assign w_item.mode         = i_in.mode;
    assign w_item.row          = i_in.row;
    assign w_item.column       = i_in.column;
    assign w_item.value        = i_in.value;
    assign w_item.last_element = i_in.last_element;
    assign i_in.ready          = w_in_ready;

    assign o_out.valid        = w_out_valid;
    assign o_out.result_value = w_out.result_value;
    assign o_out.result_row   = w_out.result_row;
    assign o_out.last_row     = w_out.last_row;

    fcl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_ni        (w_ni),
        .i_no        (w_no),
        .i_acc       (w_acc),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_out       (w_out),
        .o_wr        (w_wr),
        .o_rd        (w_rd),
        .o_s1        (w_s1),
        .o_s2_valid  (w_s2_valid),
        .o_acc_clr   (w_acc_clr)
    );

    fcl_store #(
        .MAX_IN  (MAX_IN),
        .MAX_OUT (MAX_OUT)
    ) u_store (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .o_wdata (w_wdata),
        .o_xdata (w_xdata)
    );

    fcl_mac u_mac (
        .i_clk      (i_clk),
        .i_wdata    (w_wdata),
        .i_xdata    (w_xdata),
        .i_s1       (w_s1),
        .i_s2_valid (w_s2_valid),
        .i_bias_en  (r_bias_en),
        .i_acc_clr  (w_acc_clr),
        .o_acc      (w_acc)
    );

endmodule

`default_nettype wire

// File: rtl/fcl_checker.sv
// port-level checks of the fully connected layer and their bind
`default_nettype none

module fcl_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic signed [fcl_pkg::VAL_W-1:0] i_result_value,
    input wire logic [fcl_pkg::ROW_W-1:0]        i_result_row,
    input wire logic                             i_last_row
);
    import fcl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_result_value)
            && $stable(i_result_row) && $stable(i_last_row)))
        else $error("result changed while stalled");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // loads stay blocked while rows of a run remain
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_row) |-> !i_in_ready)
        else $error("load taken in the middle of a run");

    // the highest row index is always the final row of a run
    a_top_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_result_row == {ROW_W{1'b1}})) |-> i_last_row)
        else $error("top row not marked last");

endmodule

bind int16_fully_connected_layer_top fcl_checker u_fcl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_value (o_out.result_value),
    .i_result_row   (o_out.result_row),
    .i_last_row     (o_out.last_row)
);

`default_nettype wire

// File: tb/sv/int16_fully_connected_layer_checker.sv
// result checker for the int16 fully connected layer: layer prediction and row comparison
`timescale 1ns / 1ps

module int16_fully_connected_layer_checker
    import fcl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fcl_in_if                     i_in,
    fcl_out_if                    i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    logic signed [VAL_W-1:0] weights [MAX_OUT_DEF][MAX_IN_DEF];
    logic signed [VAL_W-1:0] biases  [MAX_OUT_DEF];
    logic signed [VAL_W-1:0] x_vec   [MAX_IN_DEF];

    logic [DIM_W-1:0] in_dim  = IN_DIM_RST;
    logic [DIM_W-1:0] out_dim = OUT_DIM_RST;
    logic             bias_en = BIAS_EN_RST;

    t_out_item expected_rows [$];
    int        fails = 0;

    function automatic int clip_dim(input logic [DIM_W-1:0] d);
        return (int'(d) > DIM_CAP) ? DIM_CAP : int'(d);
    endfunction

    task automatic push_layer_rows();
        int        rows;
        int        cols;
        int        r;
        int        c;
        int        acc;
        t_out_item row_item;
        rows = clip_dim(out_dim);
        cols = clip_dim(in_dim);
        for (r = 0; r < rows; r++) begin
            acc = 0;
            for (c = 0; c < cols; c++) begin
                acc += int'(x_vec[c]) * int'(weights[r][c]);
            end
            if (bias_en) begin
                acc += int'(biases[r]);
            end
            row_item.result_value = acc[VAL_W-1:0];
            row_item.result_row   = r[ROW_W-1:0];
            row_item.last_row     = (r + 1 == rows);
            expected_rows.push_back(row_item);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            in_dim  = IN_DIM_RST;
            out_dim = OUT_DIM_RST;
            bias_en = BIAS_EN_RST;
            expected_rows.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_IN_DIM:  in_dim  = i_cfg_data[DIM_W-1:0];
                    CFG_OUT_DIM: out_dim = i_cfg_data[DIM_W-1:0];
                    CFG_BIAS_EN: bias_en = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got.result_value = i_out.result_value;
                got.result_row   = i_out.result_row;
                got.last_row     = i_out.last_row;
                if (expected_rows.size() == 0) begin
                    $error("unexpected result transaction: result_value %0d result_row %0d",
                           got.result_value, got.result_row);
                    fails++;
                end else begin
                    want = expected_rows.pop_front();
                    if (got.result_value !== want.result_value) begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               want.result_value, got.result_value);
                        fails++;
                    end
                    if (got.result_row !== want.result_row) begin
                        $error("result_row mismatch: expected %0d, actual %0d",
                               want.result_row, got.result_row);
                        fails++;
                    end
                    if (got.last_row !== want.last_row) begin
                        $error("last_row mismatch: expected %0d, actual %0d",
                               want.last_row, got.last_row);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.mode)
                    MODE_WEIGHT: weights[i_in.row][i_in.column] = i_in.value;
                    MODE_BIAS:   biases[i_in.row] = i_in.value;
                    MODE_INPUT: begin
                        x_vec[i_in.column] = i_in.value;
                        if (i_in.last_element) begin
                            push_layer_rows();
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_rows.size();
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/int16_fully_connected_layer_top_test.sv
// testbench top for the int16 fully connected layer: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module int16_fully_connected_layer_top_test;
    import fcl_pkg::*;

    localparam int ITEM_TARGET  = 310;
    localparam int PHASE_ITEMS  = 30;
    localparam int RUN_CYCLES   = 400;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int FIXED_PHASES = 8;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam logic [DIM_W-1:0] PHASE_IN  [FIXED_PHASES] =
        '{5'd31, 5'd1, 5'd0, 5'd6, 5'd16, 5'd3, 5'd0, 5'd2};
    localparam logic [DIM_W-1:0] PHASE_OUT [FIXED_PHASES] =
        '{5'd2, 5'd31, 5'd5, 5'd0, 5'd4, 5'd16, 5'd0, 5'd1};
    localparam bit               PHASE_BE  [FIXED_PHASES] =
        '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fcl_in_if  in_ch ();
    fcl_out_if out_ch ();

    int pending;
    int fail_count;
    int cycles = 0;
    int rand_items = 0;
    int rx_stall = 0;
    bit rx_burst = 1'b0;
    bit tx_burst = 1'b0;

    bit w_loaded [MAX_OUT_DEF][MAX_IN_DEF];
    bit b_loaded [MAX_OUT_DEF];
    bit x_loaded [MAX_IN_DEF];

    logic [DIM_W-1:0] cur_in  = IN_DIM_RST;
    logic [DIM_W-1:0] cur_out = OUT_DIM_RST;
    bit               cur_be  = BIAS_EN_RST;

    int16_fully_connected_layer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    int16_fully_connected_layer_checker layer_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    function automatic int clip_dim(input logic [DIM_W-1:0] d);
        return (int'(d) > DIM_CAP) ? DIM_CAP : int'(d);
    endfunction

    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) begin
            return 0;
        end
        if (p < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_below(input int n);
        return (n == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if ($urandom_range(0, 299) == 0) begin
            rx_burst <= !rx_burst;
        end
        if (rx_stall != 0) begin
            rx_stall     <= rx_stall - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (!rx_burst && $urandom_range(0, 3) == 0) begin
                rx_stall <= rand_gap();
            end
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] mode, input int row, input int col,
                             input logic [VAL_W-1:0] value, input bit last);
        int gap;
        gap = tx_burst ? 0 : rand_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.row          <= row[ROW_W-1:0];
        in_ch.column       <= col[COL_W-1:0];
        in_ch.value        <= value;
        in_ch.last_element <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        case (mode)
            MODE_WEIGHT: w_loaded[row][col] = 1'b1;
            MODE_BIAS:   b_loaded[row] = 1'b1;
            MODE_INPUT:  x_loaded[col] = 1'b1;
            default: ;
        endcase
        if (mode != MODE_NONE) begin
            rand_items++;
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [DIM_W-1:0] nin, input logic [DIM_W-1:0] nout,
                              input bit be);
        drain_results();
        repeat (RUN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IN_DIM;
        i_cfg_data <= nin;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OUT_DIM;
        i_cfg_data <= nout;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_BIAS_EN;
        i_cfg_data <= CFG_DATA_W'(be);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_in  = nin;
        cur_out = nout;
        cur_be  = be;
    endtask

    // random loads, then whatever the run still needs, then the starting element
    task automatic run_sequence();
        int ni;
        int no;
        int r;
        int c;
        ni = clip_dim(cur_in);
        no = clip_dim(cur_out);
        tx_burst = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 2))
                0: send_item(MODE_WEIGHT, rand_below(no), rand_below(ni), rand_value(),
                             1'($urandom_range(0, 1)));
                1: send_item(MODE_BIAS, rand_below(no), $urandom_range(0, 15), rand_value(),
                             1'($urandom_range(0, 1)));
                default: send_item(MODE_INPUT, $urandom_range(0, 15), rand_below(ni),
                                   rand_value(), 1'b0);
            endcase
        end
        for (r = 0; r < no; r++) begin
            for (c = 0; c < ni; c++) begin
                if (!w_loaded[r][c]) begin
                    send_item(MODE_WEIGHT, r, c, rand_value(), 1'b0);
                end
            end
            if (cur_be && !b_loaded[r]) begin
                send_item(MODE_BIAS, r, $urandom_range(0, 15), rand_value(), 1'b0);
            end
        end
        for (c = 0; c < ni; c++) begin
            if (!x_loaded[c]) begin
                send_item(MODE_INPUT, $urandom_range(0, 15), c, rand_value(), 1'b0);
            end
        end
        send_item(MODE_INPUT, $urandom_range(0, 15), $urandom_range(0, 15), rand_value(), 1'b1);
        if ($urandom_range(0, 3) == 0) begin
            drain_results();
        end
    endtask

    task automatic noise_item();
        logic [MODE_W-1:0] m;
        m = $urandom_range(0, 3);
        tx_burst = 1'b0;
        send_item(m, $urandom_range(0, 15), $urandom_range(0, 15), rand_value(),
                  (m == MODE_INPUT) ? 1'b0 : 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int phase;
        int phase_start;
        int c;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_WEIGHT;
        in_ch.row          = '0;
        in_ch.column       = '0;
        in_ch.value        = '0;
        in_ch.last_element = 1'b0;
        out_ch.ready       = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_IN_DIM;
        i_cfg_data         = '0;
        i_rst_n            = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset configuration: extremes and wrapping sums
        send_item(MODE_WEIGHT, 0, 0, 16'h7fff, 1'b1);
        send_item(MODE_WEIGHT, 0, 1, 16'h8000, 1'b0);
        send_item(MODE_WEIGHT, 0, 2, 16'hffff, 1'b0);
        send_item(MODE_WEIGHT, 0, 3, 16'h0000, 1'b0);
        for (c = 0; c < 4; c++) begin
            send_item(MODE_WEIGHT, 1, c, 16'h8000, 1'b0);
        end
        for (c = 0; c < 4; c++) begin
            send_item(MODE_WEIGHT, 2, c, rand_value(), 1'b0);
        end
        send_item(MODE_BIAS, 0, 0, 16'h7fff, 1'b1);
        send_item(MODE_BIAS, 1, 0, 16'h8000, 1'b0);
        send_item(MODE_BIAS, 2, 0, 16'h0001, 1'b0);
        send_item(MODE_NONE, 15, 15, 16'hffff, 1'b1);
        for (c = 0; c < 3; c++) begin
            send_item(MODE_INPUT, 0, c, 16'h8000, 1'b0);
        end
        send_item(MODE_INPUT, 0, 3, 16'h8000, 1'b1);
        drain_results();
        send_item(MODE_WEIGHT, 15, 15, 16'h7fff, 1'b0);
        send_item(MODE_BIAS, 15, 0, 16'h8000, 1'b0);
        send_item(MODE_INPUT, 15, 15, 16'h7fff, 1'b1);

        rand_items = 0;
        phase = 0;
        while (rand_items < ITEM_TARGET) begin
            if (phase < FIXED_PHASES) begin
                set_config(PHASE_IN[phase], PHASE_OUT[phase], PHASE_BE[phase]);
            end else if ($urandom_range(0, 5) == 0) begin
                set_config($urandom_range(9, 31), $urandom_range(0, 31), $urandom_range(0, 1));
            end else begin
                set_config($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 1));
            end
            phase++;
            phase_start = rand_items;
            while (rand_items - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 7) begin
                    run_sequence();
                end else begin
                    noise_item();
                end
            end
        end

        drain_results();
        repeat (RUN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
